>>> src/assert_macros.svh
// Assertion macros shared by the RTL.
// Needs no other file; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/smiia_pkg.sv
// Types and constants of the symbol map lookup-or-insert block.
// No dependencies; imported by smiia_table and the top level.
package smiia_pkg;

  localparam int KEY_W     = 32;
  localparam int DIR_W     = 32;
  localparam int CHAR_W    = 8;
  localparam int KEY_CHARS = KEY_W / CHAR_W;

  typedef logic [KEY_W-1:0]        key_t;
  typedef logic signed [DIR_W-1:0] dir_t;

  typedef struct packed {
    logic hit;
    logic full;
    dir_t dir;
  } lookup_t;

endpackage

>>> src/symbol_map_insert_if_absent_core.sv
// Top level of the symbol map lookup-or-insert block.
// Depends on smiia_pkg, smiia_table and assert_macros.svh.
//
// Usage:
//   Request channel: in_valid / in_stall with symbol_key and new_direction.
//   Result channel: out_valid / out_stall with direction_out, was_present
//   and table_full; exactly one result per request, in request order.
//   A key is cut at its first NUL byte (counting from the top byte) and the
//   bytes below it read as zero. A known key returns its stored direction
//   with was_present set; a new key is stored with new_direction, which is
//   returned. With all TABLE_DEPTH entries in use a new key is dropped and
//   the result has table_full set and direction_out zero.
//   A result passes through the input register, then the result register.
//   Throughput: one request per cycle while the receiver does not stall;
//   the table lookup and insert sit combinationally between the two
//   registers, so the next request already sees the updated table.
//   Reset empties the table and drops anything in flight. While the
//   receiver stalls, the result holds and the input register fills; once
//   it is full, in_stall rises.
module symbol_map_insert_if_absent_core
  import smiia_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  key_t symbol_key,
  input  dir_t new_direction,
  output logic out_valid,
  input  logic out_stall,
  output dir_t direction_out,
  output logic was_present,
  output logic table_full
);

`include "assert_macros.svh"

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic             s1_valid;
  key_t             s1_key;
  dir_t             s1_dir;
  key_t             canon_key;
  logic             advance;
  logic             commit;
  lookup_t          lookup;
  logic [CNT_W-1:0] count;

  always_comb begin
    logic ended;
    ended     = 1'b0;
    canon_key = '0;
    for (int b = KEY_CHARS - 1; b >= 0; b--) begin
      if (symbol_key[b*CHAR_W +: CHAR_W] == '0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        canon_key[b*CHAR_W +: CHAR_W] = symbol_key[b*CHAR_W +: CHAR_W];
      end
    end
  end

  assign advance  = !out_valid || !out_stall;
  assign commit   = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_key <= canon_key;
      s1_dir <= new_direction;
    end
  end

  smiia_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .commit(commit),
    .key   (s1_key),
    .dir   (s1_dir),
    .lookup(lookup),
    .count (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      was_present <= lookup.hit;
      table_full  <= !lookup.hit && lookup.full;
      if (lookup.hit) begin
        direction_out <= lookup.dir;
      end else if (lookup.full) begin
        direction_out <= '0;
      end else begin
        direction_out <= s1_dir;
      end
    end
  end

  `ASSERT_SAME(a_full_not_present, clk, rst, out_valid && table_full, !was_present, "full result marked present")
  `ASSERT_NEXT(a_insert_counts, clk, rst, commit && !lookup.hit && !lookup.full, count == $past(count) + CNT_W'(1), "insert did not advance entry count")
  `ASSERT_NEXT(a_lookup_holds_count, clk, rst, commit && lookup.hit, count == $past(count), "hit changed entry count")
  `ASSERT_NEXT(a_stage_holds, clk, rst, in_stall, s1_valid && $stable(s1_key) && $stable(s1_dir), "held request changed while stalled")

endmodule

>>> src/smiia_table.sv
// Symbol table: parallel key match, stored directions and in-order insert.
// Depends on smiia_pkg.
module smiia_table
  import smiia_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             commit,
  input  key_t             key,
  input  dir_t             dir,
  output lookup_t          lookup,
  output logic [CNT_W-1:0] count
);

  key_t                   entry_key [TABLE_DEPTH];
  dir_t                   entry_direction [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [TABLE_DEPTH-1:0] match;
  dir_t                   hit_dir;
  logic                   insert;
  logic [IDX_W-1:0]       widx;

  always_comb begin
    hit_dir = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = entry_valid[i] && (entry_key[i] == key);
      hit_dir  = hit_dir | (match[i] ? entry_direction[i] : dir_t'(0));
    end
  end

  assign lookup.hit  = |match;
  assign lookup.full = (count == CNT_W'(TABLE_DEPTH));
  assign lookup.dir  = hit_dir;

  // entries fill in order and are never removed, so the count is the lowest free slot
  assign widx   = count[IDX_W-1:0];
  assign insert = commit && !lookup.hit && !lookup.full;

  always_ff @(posedge clk) begin
    if (insert) begin
      entry_key[widx]       <= key;
      entry_direction[widx] <= dir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      count       <= '0;
    end else if (insert) begin
      entry_valid[widx] <= 1'b1;
      count             <= count + CNT_W'(1);
    end
  end

endmodule

>>> tb/sv/symbol_map_lookup_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the symbol map core, predicts each lookup-or-insert
// result and compares it with the result taken. Depends on smiia_pkg.
module symbol_map_lookup_checker
  import smiia_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  key_t symbol_key,
  input  dir_t new_direction,
  input  logic out_valid,
  input  logic out_stall,
  input  dir_t direction_out,
  input  logic was_present,
  input  logic table_full,
  output int   mismatches,
  output int   lookups_in_flight
);

  key_t                   stored_key [TABLE_DEPTH];
  dir_t                   stored_dir [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] stored_valid;
  lookup_t                expected_lookups[$];

  // Cut the key at its first NUL byte; everything below reads as zero.
  function automatic key_t trim_at_nul(key_t raw);
    key_t trimmed;
    int   b;
    trimmed = '0;
    for (b = KEY_CHARS - 1; b >= 0; b--) begin
      if (raw[b*CHAR_W +: CHAR_W] == '0) break;
      trimmed[b*CHAR_W +: CHAR_W] = raw[b*CHAR_W +: CHAR_W];
    end
    return trimmed;
  endfunction

  function automatic lookup_t lookup_or_insert(key_t raw, dir_t proposed);
    key_t    k;
    int      hit_idx;
    int      free_idx;
    lookup_t r;
    k        = trim_at_nul(raw);
    hit_idx  = -1;
    free_idx = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (stored_valid[i]) begin
        if (hit_idx < 0 && stored_key[i] == k) hit_idx = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    r = '0;
    if (hit_idx >= 0) begin
      r.hit = 1'b1;
      r.dir = stored_dir[hit_idx];
    end else if (free_idx >= 0) begin
      stored_key[free_idx]   = k;
      stored_dir[free_idx]   = proposed;
      stored_valid[free_idx] = 1'b1;
      r.dir                  = proposed;
    end else begin
      r.full = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    logic    bad;
    if (rst) begin
      stored_valid = '0;
      expected_lookups.delete();
      mismatches        <= 0;
      lookups_in_flight <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t: unexpected result dir=%0d present=%0b full=%0b", $time,
                   direction_out, was_present, table_full);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_lookups.pop_front();
          bad  = 1'b0;
          if (direction_out !== want.dir) begin
            $display("%0t: direction_out expected %0d got %0d", $time, want.dir,
                     direction_out);
            bad = 1'b1;
          end
          if (was_present !== want.hit) begin
            $display("%0t: was_present expected %0b got %0b", $time, want.hit,
                     was_present);
            bad = 1'b1;
          end
          if (table_full !== want.full) begin
            $display("%0t: table_full expected %0b got %0b", $time, want.full,
                     table_full);
            bad = 1'b1;
          end
          if (bad) mismatches <= mismatches + 1;
        end
      end
      if (in_valid && !in_stall) begin
        expected_lookups.push_back(lookup_or_insert(symbol_key, new_direction));
      end
      lookups_in_flight <= expected_lookups.size();
    end
  end

endmodule

>>> tb/sv/symbol_map_insert_if_absent_core_tb.sv
`timescale 1ns / 1ps
// Top of the symbol map core testbench: clock, reset, request and stall stimulus,
// watchdog and verdict. Needs smiia_pkg, the core and symbol_map_lookup_checker.
module symbol_map_insert_if_absent_core_tb;
  import smiia_pkg::*;

  localparam int   TABLE_DEPTH      = 32;
  localparam int   RESET_CYCLES     = 7;
  localparam int   LONG_HOLD_CYCLES = 60;
  localparam int   DRAIN_CYCLES     = 8;
  localparam int   WATCHDOG_LIMIT   = 2000;
  localparam int   POOL_LIMIT       = 48;
  localparam dir_t DIR_MIN          = dir_t'(32'h8000_0000);
  localparam dir_t DIR_MAX          = dir_t'(32'h7fff_ffff);

  logic clk           = 1'b0;
  logic rst           = 1'b1;
  logic in_valid      = 1'b0;
  logic out_stall     = 1'b0;
  key_t symbol_key    = '0;
  dir_t new_direction = '0;
  logic in_stall;
  logic out_valid;
  dir_t direction_out;
  logic was_present;
  logic table_full;
  int   mismatches;
  int   lookups_in_flight;
  int   tx_idle_pct   = 0;
  int   rx_idle_pct   = 0;
  int   hold_requests = 0;
  int   quiet_cycles  = 0;
  key_t key_pool[$];

  always #5 clk = ~clk;

  symbol_map_insert_if_absent_core #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (.*);

  symbol_map_lookup_checker #(.TABLE_DEPTH(TABLE_DEPTH)) i_checker (.*);

  // Result side: random stalls, plus a long hold whenever one is requested.
  initial begin
    int holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        for (int n = 0; n < LONG_HOLD_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input key_t k, input dir_t d);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    symbol_key    <= k;
    new_direction <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lookups_in_flight != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(input int count, input int tx_pct, input int rx_pct,
                                  input bit with_hold);
    key_t k;
    dir_t d;
    int   mode;
    int   nul_at;
    int   b;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 10) hold_requests++;
      mode = $urandom_range(99);
      if (mode < 55 && key_pool.size() != 0) begin
        k = key_pool[$urandom_range(key_pool.size() - 1)];
      end else if (mode < 75) begin
        k = $urandom;
      end else begin
        k = $urandom;
        nul_at = $urandom_range(KEY_CHARS - 1);
        k[nul_at*CHAR_W +: CHAR_W] = '0;
      end
      // scribble over the bytes below the first NUL
      if ($urandom_range(2) == 0) begin
        nul_at = -1;
        for (b = KEY_CHARS - 1; b >= 0 && nul_at < 0; b--) begin
          if (k[b*CHAR_W +: CHAR_W] == '0) nul_at = b;
        end
        if (nul_at > 0) k = k | (key_t'($urandom) & ((key_t'(1) << (nul_at * CHAR_W)) - 1));
      end
      case ($urandom_range(9))
        0:       d = DIR_MIN;
        1:       d = DIR_MAX;
        2:       d = '0;
        3:       d = '1;
        default: d = $urandom;
      endcase
      if (key_pool.size() < POOL_LIMIT) key_pool.push_back(k);
      send_request(k, d);
    end
    drain_results();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 15;
    rx_idle_pct = 62;

    send_request(32'h0000_0000, DIR_MIN);
    send_request(32'h0000_0000, 32'sd5);
    send_request(32'h00ff_ffff, 32'sd6);
    send_request(32'h4100_4200, DIR_MAX);
    send_request(32'h4100_0000, '0);
    send_request(32'h4100_ffff, '1);
    send_request(32'hffff_ffff, '1);
    send_request(32'hffff_ffff, '0);
    send_request(32'h4142_4344, 32'h1234_5678);
    send_request(32'h4142_4300, 32'sd1);
    send_request(32'h4142_4301, 32'sd2);
    send_request(32'h4142_0099, 32'sd3);
    send_request(32'h4142_0000, 32'sd4);
    send_request(32'h4142_4344, 32'sd5);
    send_request(32'h8000_0001, DIR_MIN);
    send_request(32'h0180_0000, DIR_MAX);
    drain_results();

    run_random_phase(470, 15, 62, 1'b0);
    run_random_phase(470, 62, 15, 1'b0);
    run_random_phase(460, 0, 0, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
